@@ sv/kth_lexicographic_permutation_top_defines.svh @@
// Assertion macros shared by the permutation unranker modules.
`ifndef KTH_LEXICOGRAPHIC_PERMUTATION_TOP_DEFINES_SVH
`define KTH_LEXICOGRAPHIC_PERMUTATION_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define KTHP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kthp assertion failed");
// Next-cycle implication, checked outside reset.
`define KTHP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kthp assertion failed");
`else
`define KTHP_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define KTHP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ sv/kthp_pkg.sv @@
// Types, constants and the factorial table of the permutation unranker.
package kthp_pkg;

  localparam int OUT_FIELDS = 9;
  localparam int DIGIT_W    = 4;
  localparam int LEN_W      = 4;
  localparam int RANK_W     = 20;
  localparam int REM_W      = 19;
  localparam int IDX_W      = $clog2(OUT_FIELDS + 1);
  localparam int MOD_STEPS  = RANK_W;
  localparam int CNT_W      = $clog2(MOD_STEPS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_SEL,
    ST_HOLD
  } kthp_state_t;

  typedef struct packed {
    logic load;
    logic mod_step;
    logic sel_step;
    logic out_load;
  } kthp_cmd_t;

  typedef struct packed {
    logic mod_last;
    logic digit_done;
  } kthp_sts_t;

  // Factorials 0! through 9!; codes above nine return one.
  function automatic logic [REM_W-1:0] fact_of(input logic [LEN_W-1:0] i);
    logic [REM_W-1:0] f;
    unique case (i)
      4'd0:    f = 19'd1;
      4'd1:    f = 19'd1;
      4'd2:    f = 19'd2;
      4'd3:    f = 19'd6;
      4'd4:    f = 19'd24;
      4'd5:    f = 19'd120;
      4'd6:    f = 19'd720;
      4'd7:    f = 19'd5040;
      4'd8:    f = 19'd40320;
      4'd9:    f = 19'd362880;
      default: f = 19'd1;
    endcase
    return f;
  endfunction

endpackage

@@ sv/kthp_channels.sv @@
// Request and result channel interfaces of the permutation unranker.
interface kthp_in_if;
  import kthp_pkg::*;
  logic               valid;
  logic               ready;
  logic [LEN_W-1:0]   length;
  logic [RANK_W-1:0]  rank;
  modport source (output valid, output length, output rank, input ready);
  modport sink (input valid, input length, input rank, output ready);
endinterface

interface kthp_out_if;
  import kthp_pkg::*;
  logic               valid;
  logic               ready;
  logic [DIGIT_W-1:0] pos0_digit;
  logic [DIGIT_W-1:0] pos1_digit;
  logic [DIGIT_W-1:0] pos2_digit;
  logic [DIGIT_W-1:0] pos3_digit;
  logic [DIGIT_W-1:0] pos4_digit;
  logic [DIGIT_W-1:0] pos5_digit;
  logic [DIGIT_W-1:0] pos6_digit;
  logic [DIGIT_W-1:0] pos7_digit;
  logic [DIGIT_W-1:0] pos8_digit;
  modport source (output valid, input ready,
                  output pos0_digit, output pos1_digit, output pos2_digit,
                  output pos3_digit, output pos4_digit, output pos5_digit,
                  output pos6_digit, output pos7_digit, output pos8_digit);
  modport sink (input valid, output ready,
                input pos0_digit, input pos1_digit, input pos2_digit,
                input pos3_digit, input pos4_digit, input pos5_digit,
                input pos6_digit, input pos7_digit, input pos8_digit);
endinterface

@@ sv/kthp_datapath.sv @@
// Datapath: rank reduction modulo n!, digit selection and the symbol pool.
`include "kth_lexicographic_permutation_top_defines.svh"
module kthp_datapath #(
  parameter int MAX_SYMBOLS = 9
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  kthp_pkg::kthp_cmd_t                cmd,
  output kthp_pkg::kthp_sts_t                sts,
  input  logic [kthp_pkg::LEN_W-1:0]         in_length,
  input  logic [kthp_pkg::RANK_W-1:0]        in_rank,
  output logic [kthp_pkg::DIGIT_W-1:0]       out_digits [kthp_pkg::OUT_FIELDS]
);
  import kthp_pkg::*;

  localparam int POOL_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;

  logic [LEN_W-1:0]   n_r;
  logic [RANK_W-1:0]  k_r;
  logic [REM_W-1:0]   rem_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [IDX_W-1:0]   pos_r;
  logic [POOL_W-1:0]  sel_r;
  logic [DIGIT_W-1:0] pool_r [MAX_SYMBOLS];
  logic [DIGIT_W-1:0] digits_r [OUT_FIELDS];
  logic [DIGIT_W-1:0] out_r [OUT_FIELDS];

  logic [LEN_W-1:0]   n_nxt;
  logic [RANK_W-1:0]  rem_shift;
  logic [REM_W-1:0]   modulus;
  logic [LEN_W-1:0]   avail;
  logic [REM_W-1:0]   pos_fact;
  logic               take;

  assign n_nxt = (in_length > LEN_W'(MAX_SYMBOLS)) ? LEN_W'(MAX_SYMBOLS) : in_length;
  assign modulus   = fact_of(n_r);
  assign rem_shift = {rem_r, k_r[RANK_W-1]};
  assign avail     = n_r - LEN_W'(pos_r);
  assign pos_fact  = fact_of(avail - LEN_W'(1));
  // Keep subtracting the positional factorial while the pool still has a
  // later symbol to move to.
  assign take = (rem_r >= pos_fact) && (LEN_W'(sel_r) < (avail - LEN_W'(1)));

  assign sts.mod_last   = (cnt_r == CNT_W'(MOD_STEPS - 1));
  assign sts.digit_done = (LEN_W'(pos_r) == n_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r   <= n_nxt;
      k_r   <= (in_rank == '0) ? '0 : in_rank - RANK_W'(1);
      rem_r <= '0;
      cnt_r <= '0;
      pos_r <= '0;
      sel_r <= '0;
      for (int i = 0; i < MAX_SYMBOLS; i++) begin
        pool_r[i] <= DIGIT_W'(i + 1);
      end
      for (int i = 0; i < OUT_FIELDS; i++) begin
        digits_r[i] <= '0;
      end
    end else if (cmd.mod_step) begin
      // One restoring division step per cycle; only the remainder is kept.
      rem_r <= (rem_shift >= RANK_W'(modulus)) ?
               REM_W'(rem_shift - RANK_W'(modulus)) : REM_W'(rem_shift);
      k_r   <= {k_r[RANK_W-2:0], 1'b0};
      cnt_r <= cnt_r + CNT_W'(1);
    end else if (cmd.sel_step) begin
      if (take) begin
        rem_r <= rem_r - pos_fact;
        sel_r <= sel_r + POOL_W'(1);
      end else begin
        digits_r[pos_r] <= pool_r[sel_r];
        for (int i = 0; i < MAX_SYMBOLS - 1; i++) begin
          if (POOL_W'(i) >= sel_r) begin
            pool_r[i] <= pool_r[i + 1];
          end
        end
        pool_r[MAX_SYMBOLS-1] <= '0;
        pos_r <= pos_r + IDX_W'(1);
        sel_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r <= digits_r;
    end
  end

  assign out_digits = out_r;

  `KTHP_ASSERT_NOW(a_sel_in_pool, clk, rst_n, cmd.sel_step, LEN_W'(sel_r) < avail)
  `KTHP_ASSERT_NOW(a_rem_bounded, clk, rst_n, cmd.sel_step, rem_r < fact_of(avail))
  `KTHP_ASSERT_NEXT(a_mod_done_rem, clk, rst_n, cmd.mod_step && sts.mod_last,
                    rem_r < modulus)
endmodule

@@ sv/kthp_ctrl.sv @@
// Controller: sequences reduction and digit steps and owns the result slot.
`include "kth_lexicographic_permutation_top_defines.svh"
module kthp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output kthp_pkg::kthp_cmd_t  cmd,
  input  kthp_pkg::kthp_sts_t  sts
);
  import kthp_pkg::*;

  kthp_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) begin
          state_nxt = ST_SEL;
        end
      end
      ST_SEL: begin
        if (!sts.digit_done) begin
          cmd.sel_step = 1'b1;
        end else if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  assign out_valid = out_valid_r;

  `KTHP_ASSERT_NOW(a_load_slot_free, clk, rst_n, cmd.out_load, !out_valid_r || out_ready)
  `KTHP_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_valid && in_ready, state_r == ST_MOD)
  `KTHP_ASSERT_NOW(a_no_step_done, clk, rst_n, cmd.sel_step, !sts.digit_done)
endmodule

@@ sv/kth_lexicographic_permutation_top.sv @@
// Top level of the lexicographic permutation unranker.
// Usage:
// A request on in_if carries length (n, 1 to 9, larger values are capped at
// MAX_SYMBOLS, zero gives an empty permutation) and a one-based rank k.
// Rank zero acts as rank one; ranks beyond n! wrap modulo n!.
// The result on out_if carries pos0_digit through pos8_digit, the digits of
// the k-th permutation of 1..n, with every position at or beyond n at zero.
// Both channels use valid and ready; a request moves when both are high.
// The rank reduction runs one bit per cycle of a restoring divider; each
// position then takes one compare-subtract step per step of its index plus
// one step to emit the digit and close up the pool.
// One request is worked at a time; in_if.ready is high only while idle, and
// a new request can be taken while the previous result still waits.
// If the receiver stalls, the result is held stable and the next finished
// result waits inside the block until the output register frees up.
// Reset clears the controller and the result valid flag; no clearing pass.
module kth_lexicographic_permutation_top #(
  parameter int MAX_SYMBOLS = 9
) (
  input  logic      clk,
  input  logic      rst_n,
  kthp_in_if.sink   in_if,
  kthp_out_if.source out_if
);
  import kthp_pkg::*;

  kthp_cmd_t          cmd;
  kthp_sts_t          sts;
  logic [DIGIT_W-1:0] digits [OUT_FIELDS];

  kthp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  kthp_datapath #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_length  (in_if.length),
    .in_rank    (in_if.rank),
    .out_digits (digits)
  );

  assign out_if.pos0_digit = digits[0];
  assign out_if.pos1_digit = digits[1];
  assign out_if.pos2_digit = digits[2];
  assign out_if.pos3_digit = digits[3];
  assign out_if.pos4_digit = digits[4];
  assign out_if.pos5_digit = digits[5];
  assign out_if.pos6_digit = digits[6];
  assign out_if.pos7_digit = digits[7];
  assign out_if.pos8_digit = digits[8];
endmodule
